/* rtl/core/yuvrgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// shared types, coefficients and codes for the 4:2:2 to rgb888 converter
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    // signed width that holds every bt.601 product and sum
    localparam int SUM_W = 20;
    localparam int Q_W   = SUM_W - 8;

    localparam logic signed [SUM_W-1:0] K_LUMA      = 298;
    localparam logic signed [SUM_W-1:0] K_CR_RED    = 409;
    localparam logic signed [SUM_W-1:0] K_CB_GREEN  = 100;
    localparam logic signed [SUM_W-1:0] K_CR_GREEN  = 208;
    localparam logic signed [SUM_W-1:0] K_CB_BLUE   = 516;
    localparam logic signed [SUM_W-1:0] K_ROUND     = 128;
    localparam logic signed [8:0]       LUMA_OFS    = 16;
    localparam logic signed [8:0]       CHROMA_OFS  = 128;
    localparam logic signed [Q_W-1:0]   PIX_MAX     = 255;

    // byte order codes
    localparam logic [1:0] ORDER_YUYV = 2'd0;
    localparam logic [1:0] ORDER_UYVY = 2'd1;
    localparam logic [1:0] ORDER_YYUV = 2'd2;

    // register indexes
    localparam logic CFG_BYTE_ORDER = 1'b0;
    localparam logic CFG_FLIP_IMAGE = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // stage advance strobes shared by the lanes
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } pipe_ctrl_t;

    // floor shift by 8, then clamp to 0..255
    function automatic logic [7:0] clamp_pixel(input logic signed [SUM_W-1:0] sum);
        logic signed [Q_W-1:0] q;
        q = sum[SUM_W-1:8];
        if (q < 0) begin
            return 8'd0;
        end else if (q > PIX_MAX) begin
            return 8'hFF;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

/* rtl/core/yuvrgb_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvrgb_lane
// one pixel of conversion: constant products, then sum, shift and clamp
// ----------------------------------------------------------------------------
module yuvrgb_lane
    import yuvrgb_pkg::*;
(
    input  logic       aclk,
    input  pipe_ctrl_t ctrl,
    input  logic [7:0] luma,
    input  logic [7:0] cb,
    input  logic [7:0] cr,
    output rgb_t       pix
);

    logic signed [8:0]       c_val;
    logic signed [8:0]       d_val;
    logic signed [8:0]       e_val;

    logic signed [SUM_W-1:0] luma_prod_reg,     luma_prod_next;
    logic signed [SUM_W-1:0] cr_red_reg,        cr_red_next;
    logic signed [SUM_W-1:0] cb_green_reg,      cb_green_next;
    logic signed [SUM_W-1:0] cr_green_reg,      cr_green_next;
    logic signed [SUM_W-1:0] cb_blue_reg,       cb_blue_next;
    logic signed [SUM_W-1:0] red_sum;
    logic signed [SUM_W-1:0] green_sum;
    logic signed [SUM_W-1:0] blue_sum;
    rgb_t                    pix_reg,           pix_next;

    always_comb begin
        c_val = $signed({1'b0, luma}) - LUMA_OFS;
        d_val = $signed({1'b0, cb}) - CHROMA_OFS;
        e_val = $signed({1'b0, cr}) - CHROMA_OFS;

        luma_prod_next = SUM_W'(c_val) * K_LUMA;
        cr_red_next    = SUM_W'(e_val) * K_CR_RED;
        cb_green_next  = SUM_W'(d_val) * K_CB_GREEN;
        cr_green_next  = SUM_W'(e_val) * K_CR_GREEN;
        cb_blue_next   = SUM_W'(d_val) * K_CB_BLUE;
    end

    always_comb begin
        red_sum   = luma_prod_reg + cr_red_reg + K_ROUND;
        green_sum = luma_prod_reg - cb_green_reg - cr_green_reg + K_ROUND;
        blue_sum  = luma_prod_reg + cb_blue_reg + K_ROUND;

        pix_next.red   = clamp_pixel(red_sum);
        pix_next.green = clamp_pixel(green_sum);
        pix_next.blue  = clamp_pixel(blue_sum);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s1_en) begin
            luma_prod_reg <= luma_prod_next;
            cr_red_reg    <= cr_red_next;
            cb_green_reg  <= cb_green_next;
            cr_green_reg  <= cr_green_next;
            cb_blue_reg   <= cb_blue_next;
        end
        if (ctrl.s2_en) begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

/* rtl/core/yuvrgb_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvrgb_merge
// output register: orders the two lane pixels into lead and trail
// ----------------------------------------------------------------------------
module yuvrgb_merge
    import yuvrgb_pkg::*;
(
    input  logic aclk,
    input  logic out_en,
    input  logic flip,
    input  rgb_t pix_y0,
    input  rgb_t pix_y1,
    input  logic last_in,
    output rgb_t lead,
    output rgb_t trail,
    output logic last_out
);

    rgb_t lead_reg,  lead_next;
    rgb_t trail_reg, trail_next;
    logic last_reg,  last_next;

    always_comb begin
        // mirrored output sends the second pixel first
        lead_next  = flip ? pix_y1 : pix_y0;
        trail_next = flip ? pix_y0 : pix_y1;
        last_next  = last_in;
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            lead_reg  <= lead_next;
            trail_reg <= trail_next;
            last_reg  <= last_next;
        end
    end

    assign lead     = lead_reg;
    assign trail    = trail_reg;
    assign last_out = last_reg;

endmodule

/* rtl/core/yuv422_to_rgb_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb_converter_top
// 4:2:2 macropixel to two rgb888 pixels, bt.601 integer coefficients
// ----------------------------------------------------------------------------
// Takes one macropixel (four bytes) per transaction and returns one transaction
// carrying two rgb888 pixels that share the macropixel chroma. Throughput is
// one macropixel per clock with m_tready high. There are three register stages
// (product register, sum/clamp register, output register): the edge that
// accepts a macropixel loads the first one, and the third drives m_tvalid. Two
// identical conversion lanes handle the Y0 and Y1 pixels in parallel and a
// merge stage orders them, swapping the pair when flip_image is set. The
// byte order register selects YUYV, UYVY or YYUV (code 3 behaves as YUYV).
// Configuration registers should only be written while the pipeline is empty.
// tlast passes through with its macropixel. Every stage holds under output
// backpressure. s_tready is low only when all three stages are full and
// m_tready is low, so it depends combinationally on m_tready.
// ----------------------------------------------------------------------------
module yuv422_to_rgb_converter_top
    import yuvrgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata,

    // macropixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first_byte, second_byte, third_byte, fourth_byte
    input  logic        s_tlast,   // frame_last_in

    // rgb pixel pair output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red_lead, green_lead, blue_lead,
                                   // red_trail, green_trail, blue_trail
    output logic        m_tlast    // frame_last_out
);

    // configuration registers
    logic [1:0] byte_order_reg;
    logic       flip_image_reg;

    // pipeline occupancy
    logic       s1_valid_reg, s1_valid_next;
    logic       s2_valid_reg, s2_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       s1_last_reg;
    logic       s2_last_reg;

    logic       out_ready;
    logic       s2_ready;
    logic       s1_ready;
    pipe_ctrl_t pipe_ctrl;
    logic       out_en;

    // unpacked macropixel
    logic [7:0] byte0, byte1, byte2, byte3;
    logic [7:0] y0_sel, y1_sel, u_sel, v_sel;

    rgb_t       pix_y0;
    rgb_t       pix_y1;
    rgb_t       lead;
    rgb_t       trail;
    logic       last_out;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg <= ORDER_YUYV;
            flip_image_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BYTE_ORDER: byte_order_reg <= cfg_wdata;
                CFG_FLIP_IMAGE: flip_image_reg <= cfg_wdata[0];
                default:        byte_order_reg <= byte_order_reg;
            endcase
        end
    end

    // each stage moves when the stage after it is empty or moving
    always_comb begin
        out_ready       = !out_valid_reg || m_tready;
        s2_ready        = !s2_valid_reg || out_ready;
        s1_ready        = !s1_valid_reg || s2_ready;
        pipe_ctrl.s1_en = s1_ready;
        pipe_ctrl.s2_en = s2_ready;
        out_en          = out_ready;
    end

    assign s_tready = s1_ready;

    always_comb begin
        s1_valid_next  = s1_ready  ? s_tvalid     : s1_valid_reg;
        s2_valid_next  = s2_ready  ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame-end mark rides alongside the lane registers
    always_ff @(posedge aclk) begin
        if (pipe_ctrl.s1_en) begin
            s1_last_reg <= s_tlast;
        end
        if (pipe_ctrl.s2_en) begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // byte order steering
    always_comb begin
        byte0 = s_tdata[7:0];
        byte1 = s_tdata[15:8];
        byte2 = s_tdata[23:16];
        byte3 = s_tdata[31:24];
        case (byte_order_reg)
            ORDER_UYVY: begin
                u_sel  = byte0;
                y0_sel = byte1;
                v_sel  = byte2;
                y1_sel = byte3;
            end
            ORDER_YYUV: begin
                y0_sel = byte0;
                y1_sel = byte1;
                u_sel  = byte2;
                v_sel  = byte3;
            end
            default: begin
                // yuyv, and the unused code
                y0_sel = byte0;
                u_sel  = byte1;
                y1_sel = byte2;
                v_sel  = byte3;
            end
        endcase
    end

    // lane for the first luma sample
    yuvrgb_lane u_lane_y0 (
        .aclk (aclk),
        .ctrl (pipe_ctrl),
        .luma (y0_sel),
        .cb   (u_sel),
        .cr   (v_sel),
        .pix  (pix_y0)
    );

    // lane for the second luma sample
    yuvrgb_lane u_lane_y1 (
        .aclk (aclk),
        .ctrl (pipe_ctrl),
        .luma (y1_sel),
        .cb   (u_sel),
        .cr   (v_sel),
        .pix  (pix_y1)
    );

    // pixel ordering and output register
    yuvrgb_merge u_merge (
        .aclk     (aclk),
        .out_en   (out_en),
        .flip     (flip_image_reg),
        .pix_y0   (pix_y0),
        .pix_y1   (pix_y1),
        .last_in  (s2_last_reg),
        .lead     (lead),
        .trail    (trail),
        .last_out (last_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {trail.blue, trail.green, trail.red, lead.blue, lead.green, lead.red};
    assign m_tlast  = last_out;

`ifndef ASSERT_OFF
    // an accepted transaction always lands in the first stage
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted macropixel not captured in stage 1");

    // an empty first stage never refuses input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty stage 1");

    // a full pipeline behind a stalled output must stall the input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s1_valid_reg && s2_valid_reg |-> !s_tready)
        else $error("input accepted into a full stalled pipeline");

    // a stage-2 result is held while the output cannot take it
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !out_ready |=> s2_valid_reg)
        else $error("stage 2 result dropped under backpressure");
`endif

endmodule

/* tb/sv/yuv422_to_rgb_converter_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb_converter_top_test
// self-checking bench for the 4:2:2 macropixel to rgb888 converter
// ----------------------------------------------------------------------------
// An initial block queues macropixels (a directed set of extreme and
// reference colors, then random macropixels), phase by phase, and sets the
// byte order and flip registers between phases while the pipeline is empty.
// A clocked driver presents queued macropixels on the input stream, and each
// accepted transaction is converted by a bt.601 integer predictor into an
// expected pixel pair. A clocked monitor checks every output transaction,
// field by field, against the oldest expected pair. Sender gaps and receiver
// stalls are inserted at random, with rates changing from phase to phase.
// ----------------------------------------------------------------------------
module yuv422_to_rgb_converter_top_test
    import yuvrgb_pkg::*;
;

    // byte order code 3 has no meaning of its own and must act as yuyv
    localparam logic [1:0] ORDER_UNDEFINED = 2'd3;

    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 136;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one macropixel as it sits on the input stream
    typedef struct packed {
        logic        last;
        logic [31:0] bytes;   // first byte in bits 7:0
    } macropixel_t;

    // the pixel pair a macropixel must turn into
    typedef struct packed {
        rgb_t lead;
        rgb_t trail;
        logic last;
    } pixel_pair_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    // bench copy of the configuration registers, reset values
    logic [1:0]  order_sel = ORDER_YUYV;
    logic        flip_sel  = 1'b0;

    // idle rates in percent for the current phase
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    macropixel_t macropixel_q[$];   // waiting to be driven
    pixel_pair_t pixel_pair_q[$];   // predicted, waiting for the output

    int unsigned mp_accepted   = 0;
    int unsigned pairs_checked = 0;
    int unsigned mismatches    = 0;

    always #2 aclk = ~aclk;

    yuv422_to_rgb_converter_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor division by 256, then saturate to one byte
    function automatic logic [7:0] saturate_u8(input int sum);
        int q;
        q = sum >>> 8;
        if (q < 0) begin
            return 8'd0;
        end
        if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic rgb_t bt601_pixel(input int luma, input int cb, input int cr);
        int   c;
        int   d;
        int   e;
        rgb_t px;
        c = luma - int'(LUMA_OFS);
        d = cb - int'(CHROMA_OFS);
        e = cr - int'(CHROMA_OFS);
        px.red   = saturate_u8(int'(K_LUMA) * c + int'(K_CR_RED) * e + int'(K_ROUND));
        px.green = saturate_u8(int'(K_LUMA) * c - int'(K_CB_GREEN) * d
                               - int'(K_CR_GREEN) * e + int'(K_ROUND));
        px.blue  = saturate_u8(int'(K_LUMA) * c + int'(K_CB_BLUE) * d + int'(K_ROUND));
        return px;
    endfunction

    // split the macropixel by the current byte order and convert both lumas
    function automatic pixel_pair_t convert_macropixel(input logic [31:0] bytes,
                                                       input logic last);
        int          y0;
        int          y1;
        int          cb;
        int          cr;
        rgb_t        px0;
        rgb_t        px1;
        pixel_pair_t pair;
        case (order_sel)
            ORDER_UYVY: begin
                cb = int'(bytes[7:0]);   y0 = int'(bytes[15:8]);
                cr = int'(bytes[23:16]); y1 = int'(bytes[31:24]);
            end
            ORDER_YYUV: begin
                y0 = int'(bytes[7:0]);   y1 = int'(bytes[15:8]);
                cb = int'(bytes[23:16]); cr = int'(bytes[31:24]);
            end
            default: begin
                // yuyv, and the undefined code falls back to it
                y0 = int'(bytes[7:0]);   cb = int'(bytes[15:8]);
                y1 = int'(bytes[23:16]); cr = int'(bytes[31:24]);
            end
        endcase
        px0 = bt601_pixel(y0, cb, cr);
        px1 = bt601_pixel(y1, cb, cr);
        pair.lead  = flip_sel ? px1 : px0;
        pair.trail = flip_sel ? px0 : px1;
        pair.last  = last;
        return pair;
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued macropixels, predicts on each accepted one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_proc
        macropixel_t mp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // transaction accepted at this edge: record what must come out
            if (s_tvalid && s_tready) begin
                pixel_pair_q.push_back(convert_macropixel(s_tdata, s_tlast));
                mp_accepted++;
            end
            // free to present the next macropixel, or to insert a gap
            if (!s_tvalid || s_tready) begin
                if (macropixel_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    mp = macropixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= mp.bytes;
                    s_tlast  <= mp.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: compares each output transaction with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor_proc
        pixel_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_pair_q.size() == 0) begin
                $display("%0t ns: output transaction with nothing expected, actual data %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pixel_pair_q.pop_front();
                // m_tdata fields from bit 0 up: lead r g b, trail r g b
                check_field("red_lead",    want.lead.red,    m_tdata[7:0]);
                check_field("green_lead",  want.lead.green,  m_tdata[15:8]);
                check_field("blue_lead",   want.lead.blue,   m_tdata[23:16]);
                check_field("red_trail",   want.trail.red,   m_tdata[31:24]);
                check_field("green_trail", want.trail.green, m_tdata[39:32]);
                check_field("blue_trail",  want.trail.blue,  m_tdata[47:40]);
                check_field("frame_last",  {7'd0, want.last}, {7'd0, m_tlast});
                pairs_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_macropixel(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic last);
        macropixel_t mp;
        mp.bytes = {b3, b2, b1, b0};
        mp.last  = last;
        macropixel_q.push_back(mp);
    endtask

    // mostly uniform, with a share of values at the edges of the video range
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[6] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd240};
        if ($urandom_range(3) == 0) begin
            return edges[$urandom_range(5)];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_random(input int count);
        repeat (count) begin
            queue_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                             $urandom_range(15) == 0);
        end
    endtask

    // pipeline empty: nothing queued, nothing presented, nothing outstanding
    task automatic wait_drained();
        @(negedge aclk);
        while (macropixel_q.size() != 0 || s_tvalid || pixel_pair_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BYTE_ORDER) begin
            order_sel = value;
        end else begin
            flip_sel = value[0];
        end
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_gap_pct = 51; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 51; end
            IDLE_BOTH:     begin send_gap_pct = 14; recv_stall_pct = 14; end
            default:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_proc
        logic [1:0] order_code;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed set under reset configuration (yuyv, no flip)
        set_idle(IDLE_NONE);
        queue_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0); // all low, red and blue clamp at 0
        queue_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1); // all high, red and blue clamp at 255
        queue_macropixel(8'd16,  8'd128, 8'd16,  8'd128, 1'b0); // video black
        queue_macropixel(8'd235, 8'd128, 8'd235, 8'd128, 1'b0); // video white
        queue_macropixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b0); // luma extremes, one pair
        queue_macropixel(8'd255, 8'd255, 8'd0,   8'd0,   1'b1);
        queue_macropixel(8'd128, 8'd0,   8'd128, 8'd0,   1'b0); // chroma minimum
        queue_macropixel(8'd128, 8'd255, 8'd128, 8'd255, 1'b0); // chroma maximum
        queue_macropixel(8'd81,  8'd90,  8'd81,  8'd240, 1'b0); // saturated red
        queue_macropixel(8'd145, 8'd54,  8'd145, 8'd34,  1'b0); // saturated green
        queue_macropixel(8'd41,  8'd240, 8'd41,  8'd110, 1'b0); // saturated blue
        queue_macropixel(8'd0,   8'd128, 8'd1,   8'd128, 1'b0); // negative sums, floor shift
        queue_macropixel(8'd16,  8'd129, 8'd17,  8'd127, 1'b0); // small negative red
        queue_macropixel(8'd20,  8'd128, 8'd19,  8'd128, 1'b1); // rounding near zero
        queue_macropixel(8'd15,  8'd127, 8'd254, 8'd129, 1'b0);
        wait_drained();

        // random phases: every byte order code, both flip settings, all idle patterns
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                1:       order_code = ORDER_UYVY;
                2:       order_code = ORDER_YYUV;
                3:       order_code = ORDER_UNDEFINED;
                default: order_code = ORDER_YUYV;
            endcase
            repeat (4) @(posedge aclk);
            write_reg(CFG_BYTE_ORDER, order_code);
            write_reg(CFG_FLIP_IMAGE, {1'b0, p >= 4});
            set_idle(idle_mode_t'((p + p / 4) % 4));

            // sender holds off midway until every prediction has been matched
            queue_random(ITEMS_PER_PHASE / 2);
            wait_drained();
            queue_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            wait_drained();
        end

        // three-stage pipeline: give any stray output time to show up
        repeat (12) @(posedge aclk);
        if (pixel_pair_q.size() != 0) begin
            $display("%0t ns: %0d expected pixel pairs never arrived", $time,
                     pixel_pair_q.size());
            mismatches++;
        end

        $display("%0d macropixels converted, %0d pixel pairs checked, %0d mismatches",
                 mp_accepted, pairs_checked, mismatches);
        $display("covered yuyv, uyvy, yyuv and the undefined order, flipped and not, %s",
                 "under sender gaps and receiver stalls");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("timeout with %0d pixel pairs still expected", pixel_pair_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
